// ===== rtl/lbs_pkg.sv =====
// Package with the transaction types and constants shared by the skinning block.
package lbs_pkg;

    // Operation codes carried in the operation field.
    localparam logic OP_MATRIX    = 1'b0;
    localparam logic OP_INFLUENCE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_WEIGHT_MODE = 1'b0;
    localparam logic CFG_BONE_COUNT  = 1'b1;

    // Status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Sizes and defaults.
    localparam int MAX_BONES_DEF      = 256;
    localparam int MAX_INFLUENCES_DEF = 12;
    localparam int WORDS_PER_BONE     = 12;
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_W              = 9;
    localparam int ACC_W              = 64;
    localparam int WT_W               = 20;
    localparam int NEG_RATIO          = 10000;
    localparam int SCALE_8            = 255;
    localparam int SCALE_16           = 65535;
    localparam logic [CFG_W-1:0] BONE_COUNT_RESET = 9'd256;

    // One input transaction.
    typedef struct packed {
        logic               operation;
        logic [7:0]         bone_index;
        logic [3:0]         matrix_word;
        logic signed [31:0] matrix_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        weight;
        logic               last_influence;
        logic [15:0]        vertex_tag;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic signed [31:0] skinned_x;
        logic signed [31:0] skinned_y;
        logic signed [31:0] skinned_z;
        logic               status;
        logic [15:0]        vertex_out;
    } out_item_t;

endpackage

// ===== rtl/lbs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module lbs_div #(
    parameter int NW = 64,
    parameter int DW = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);
    localparam int CW = (NW > 1) ? $clog2(NW) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] dvs_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;

    // One trial subtraction per cycle.
    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    // Control state of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/linear_blend_vertex_skinning.sv =====
// Linear blend skinning top level: bone matrix memory, sequencer and output register.
//
// Input channel (in_valid/in_ready/in_data) carries two kinds of transaction.
// A matrix write stores one signed Q16.16 word of a bone matrix. An influence
// transaction adds weight times the bone-transformed point to the running
// sums. For an active influence, each of the three columns needs four matrix
// reads from the single-port memory, three multiplies into a Q32.32 sum,
// rounding, translation and a weight multiply. A skipped influence leaves
// the sums unchanged.
// On the last influence the sums are divided by the weight total with a
// bit-serial divider, unless the weight sum is negligible, in which case a
// failed result with a zero point is reported. The result goes to an output
// register (out_valid/out_ready), and the block takes new transactions while
// it waits there; a second vertex end waits until the register is free.
// Configuration (cfg_we/cfg_index/cfg_data) must be written only while idle; the block itself does not enforce it.
// Reset clears the sums and counters and sets 16-bit weights and 256 bones.
// The matrix memory is not cleared; load every used word before use.
module linear_blend_vertex_skinning #(
    parameter int MAX_BONES      = lbs_pkg::MAX_BONES_DEF,
    parameter int MAX_INFLUENCES = lbs_pkg::MAX_INFLUENCES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  lbs_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output lbs_pkg::out_item_t                 out_data,
    input  logic                               cfg_we,
    input  logic [lbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lbs_pkg::CFG_W-1:0]          cfg_data
);
    import lbs_pkg::*;

    localparam int DEPTH  = MAX_BONES * WORDS_PER_BONE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_INFLUENCES + 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_READ  = 11'b00000000010,
        S_MULT  = 11'b00000000100,
        S_ACC   = 11'b00000001000,
        S_TRANS = 11'b00000010000,
        S_WMUL  = 11'b00000100000,
        S_WACC  = 11'b00001000000,
        S_FIN   = 11'b00010000000,
        S_DIV   = 11'b00100000000,
        S_DWAIT = 11'b01000000000,
        S_EMIT  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0]        mem [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_en;

    in_item_t           item_reg;
    logic [15:0]        w_reg;
    logic [1:0]         col_reg;
    logic [1:0]         k_reg;
    logic signed [63:0] prod_reg;
    logic signed [65:0] psum_reg;
    logic signed [31:0] m3_reg;
    logic signed [31:0] t_reg;
    logic signed [47:0] tw_reg;
    logic signed [ACC_W-1:0] acc_reg [3];
    logic [WT_W-1:0]    wtot_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               wmode_reg;
    logic [CFG_W-1:0]   bcount_reg;
    logic [31:0]        res_reg [3];
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic               accept;
    logic               counted;
    logic [15:0]        w_eff;
    logic               active;
    logic               slot_free;
    logic               negligible;
    logic               out_set;
    logic [33:0]        wprod;
    logic [15:0]        scale;
    logic [3:0]         word_off;
    logic signed [31:0] pos_sel;
    logic signed [65:0] rnd;
    logic signed [65:0] tsum;
    logic signed [31:0] t_sat;
    logic               div_start;
    logic               div_done;
    logic [ACC_W-1:0]   div_num;
    logic [ACC_W-1:0]   div_q;
    logic [ACC_W-1:0]   mag;
    logic [31:0]        q_clamped;

    // Bone base address, bone * 12 as shifts.
    function automatic logic [ADDR_W-1:0] bone_base(input logic [7:0] b);
        logic [ADDR_W-1:0] bw;
        bw = ADDR_W'(b);
        return (bw << 3) + (bw << 2);
    endfunction

    // Decode of the incoming transaction.
    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign counted   = (32'(cnt_reg) < MAX_INFLUENCES);
    assign w_eff     = wmode_reg ? in_data.weight : {8'b0, in_data.weight[7:0]};
    assign active    = counted && (w_eff != 16'd0)
                       && ({1'b0, in_data.bone_index} < bcount_reg)
                       && (32'(in_data.bone_index) < MAX_BONES);
    assign slot_free = !out_valid_reg || out_ready;

    // Matrix memory ports.
    assign wr_en   = accept && (in_data.operation == OP_MATRIX)
                     && (32'(in_data.matrix_word) < WORDS_PER_BONE)
                     && (32'(in_data.bone_index) < MAX_BONES);
    assign wr_addr = bone_base(in_data.bone_index) + ADDR_W'(in_data.matrix_word);
    assign word_off = {k_reg, 1'b0} + {2'b0, k_reg} + {2'b0, col_reg};
    assign rd_addr = bone_base(item_reg.bone_index) + ADDR_W'(word_off);
    assign rd_en   = (state_reg == S_READ);

    // Single-port style memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_data.matrix_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Point coordinate for the current matrix row.
    always_comb
    begin
        unique case (k_reg)
            2'd0:    pos_sel = item_reg.pos_x;
            2'd1:    pos_sel = item_reg.pos_y;
            default: pos_sel = item_reg.pos_z;
        endcase
    end

    // Round Q32.32 to Q16.16 with ties upward, add translation, saturate.
    assign rnd  = psum_reg + 66'sd32768;
    assign tsum = (rnd >>> 16) + 66'(m3_reg);
    always_comb
    begin
        if (tsum[65:31] == '0 || tsum[65:31] == '1)
        begin
            t_sat = tsum[31:0];
        end
        else if (tsum[65])
        begin
            t_sat = 32'sh8000_0000;
        end
        else
        begin
            t_sat = 32'sh7FFF_FFFF;
        end
    end

    // Negligible weight sum test.
    assign scale      = wmode_reg ? 16'(SCALE_16) : 16'(SCALE_8);
    assign wprod      = 34'(wtot_reg) * 34'(NEG_RATIO);
    assign negligible = wprod <= 34'(scale);

    // A result enters the output register on a failed vertex or after the divides.
    assign out_set = ((state_reg == S_FIN) && slot_free && negligible)
                     || (state_reg == S_EMIT);

    // Divider operand: magnitude plus half the divisor gives round to nearest.
    assign mag       = acc_reg[col_reg][ACC_W-1] ? (ACC_W'(0) - acc_reg[col_reg])
                                                 : acc_reg[col_reg];
    assign div_num   = mag + ACC_W'(wtot_reg >> 1);
    assign div_start = (state_reg == S_DIV);

    lbs_div #(
        .NW (ACC_W),
        .DW (WT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (wtot_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Signed, saturated quotient.
    always_comb
    begin
        if (acc_reg[col_reg][ACC_W-1])
        begin
            q_clamped = (div_q >= ACC_W'(64'h8000_0000)) ? 32'h8000_0000
                                                         : (32'd0 - div_q[31:0]);
        end
        else
        begin
            q_clamped = (div_q > ACC_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q[31:0];
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_data.operation == OP_INFLUENCE)
                begin
                    if (active)
                    begin
                        state_next = S_READ;
                    end
                    else if (in_data.last_influence)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_READ:  state_next = S_MULT;
            S_MULT:  state_next = (k_reg == 2'd3) ? S_TRANS : S_ACC;
            S_ACC:   state_next = S_READ;
            S_TRANS: state_next = S_WMUL;
            S_WMUL:  state_next = S_WACC;
            S_WACC:
            begin
                if (col_reg != 2'd2)
                begin
                    state_next = S_READ;
                end
                else if (item_reg.last_influence)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    state_next = negligible ? S_IDLE : S_DIV;
                end
            end
            S_DIV:   state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = (col_reg == 2'd2) ? S_EMIT : S_DIV;
                end
            end
            S_EMIT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, configuration, sums and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wmode_reg     <= 1'b1;
            bcount_reg    <= BONE_COUNT_RESET;
            cnt_reg       <= '0;
            wtot_reg      <= '0;
            acc_reg[0]    <= '0;
            acc_reg[1]    <= '0;
            acc_reg[2]    <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WEIGHT_MODE: wmode_reg  <= cfg_data[0];
                    CFG_BONE_COUNT:  bcount_reg <= cfg_data;
                    default:         ;
                endcase
            end

            if (out_set)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && in_data.operation == OP_INFLUENCE && counted)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    col_reg <= '0;
                    k_reg   <= '0;
                end
                S_ACC:
                begin
                    k_reg <= k_reg + 1'b1;
                end
                S_WACC:
                begin
                    acc_reg[col_reg] <= acc_reg[col_reg] + ACC_W'(tw_reg);
                    k_reg            <= '0;
                    if (col_reg == 2'd2)
                    begin
                        wtot_reg <= wtot_reg + WT_W'(w_reg);
                        col_reg  <= '0;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                S_FIN:
                begin
                    col_reg <= '0;
                    if (slot_free && negligible)
                    begin
                        cnt_reg       <= '0;
                        wtot_reg      <= '0;
                        acc_reg[0]    <= '0;
                        acc_reg[1]    <= '0;
                        acc_reg[2]    <= '0;
                    end
                end
                S_DWAIT:
                begin
                    if (div_done && col_reg != 2'd2)
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                S_EMIT:
                begin
                    cnt_reg       <= '0;
                    wtot_reg      <= '0;
                    acc_reg[0]    <= '0;
                    acc_reg[1]    <= '0;
                    acc_reg[2]    <= '0;
                    col_reg       <= '0;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
            w_reg    <= w_eff;
        end
        unique case (state_reg)
            S_READ:
            begin
                if (k_reg == 2'd0)
                begin
                    psum_reg <= '0;
                end
            end
            S_MULT:
            begin
                if (k_reg == 2'd3)
                begin
                    m3_reg <= rd_data_reg;
                end
                else
                begin
                    prod_reg <= pos_sel * rd_data_reg;
                end
            end
            S_ACC:   psum_reg <= psum_reg + 66'(prod_reg);
            S_TRANS: t_reg    <= t_sat;
            S_WMUL:  tw_reg   <= t_reg * $signed({1'b0, w_reg});
            S_DWAIT:
            begin
                if (div_done)
                begin
                    res_reg[col_reg] <= q_clamped;
                end
            end
            default: ;
        endcase

        if (state_reg == S_FIN && slot_free && negligible)
        begin
            out_reg.skinned_x  <= '0;
            out_reg.skinned_y  <= '0;
            out_reg.skinned_z  <= '0;
            out_reg.status     <= STATUS_FAIL;
            out_reg.vertex_out <= item_reg.vertex_tag;
        end
        else if (state_reg == S_EMIT)
        begin
            out_reg.skinned_x  <= res_reg[0];
            out_reg.skinned_y  <= res_reg[1];
            out_reg.skinned_z  <= res_reg[2];
            out_reg.status     <= STATUS_OK;
            out_reg.vertex_out <= item_reg.vertex_tag;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/lbs_checker.sv =====
// Port-level checker for the skinning block and its bind statement.
module lbs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input lbs_pkg::in_item_t             in_data,
    input logic                          out_valid,
    input logic                          out_ready,
    input lbs_pkg::out_item_t            out_data,
    input logic                          cfg_we,
    input logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [lbs_pkg::CFG_W-1:0]     cfg_data
);
    import lbs_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A failed vertex reports a zero point.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STATUS_FAIL |->
        out_data.skinned_x == 0 && out_data.skinned_y == 0 && out_data.skinned_z == 0)
        else $error("failed vertex with nonzero point");

    // A matrix write never produces a result.
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.operation == OP_MATRIX && !out_valid |=> !out_valid)
        else $error("result after matrix write");

    // An influence that does not end the vertex produces no result.
    a_mid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.operation == OP_INFLUENCE
        && !in_data.last_influence && !out_valid |=> !out_valid)
        else $error("result before last influence");

endmodule

bind linear_blend_vertex_skinning lbs_checker u_lbs_checker (.*);
